>>> src/sha256_byte_stream_hasher_unit_assert.svh
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH

// same-cycle implication
`define SHABS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shabs assertion failed");

// next-cycle implication
`define SHABS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shabs assertion failed");

`endif

>>> src/shabs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: package
// Word types, round constants, initial hash, sigma functions and the sequencer/core link.
// ----------------------------------------------------------------------------
package shabs_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [31:0] word_t;
	typedef logic [63:0] dword_t;
	typedef logic [5:0]  count_t;

	localparam byte_t  PAD_BYTE   = 8'h80;
	localparam count_t LEN_OFFSET = 6'd56;
	localparam count_t COUNT_LAST = 6'd63;

	localparam word_t INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic  push;
		byte_t push_byte;
		logic  start;
		logic  reinit;
	} ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} stat_t;

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

>>> src/shabs_if.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: channel interfaces
// Message byte channel and digest channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface shabs_msg_if;
	import shabs_pkg::*;

	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  byte_present;
	logic  end_of_message;

	modport source (output valid, output data_byte, output byte_present,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input byte_present,
		input end_of_message, output ready);
endinterface

interface shabs_digest_if;
	import shabs_pkg::*;

	logic   valid;
	logic   ready;
	dword_t digest_word0;
	dword_t digest_word1;
	dword_t digest_word2;
	dword_t digest_word3;

	modport source (output valid, output digest_word0, output digest_word1,
		output digest_word2, output digest_word3, input ready);
	modport sink (input valid, input digest_word0, input digest_word1,
		input digest_word2, input digest_word3, output ready);
endinterface

>>> src/sha256_byte_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: top level
// Absorbs message bytes, pads at end of message and returns the digest.
//
//   channel   dir   beat payload
//   msg       in    data_byte, byte_present, end_of_message
//   digest    out   digest_word0 .. digest_word3
//
// A byte beat is taken while the unit is idle; the beat that fills a block starts
// a compression (64 rounds on the shared round unit, one fold).
// End of message: padding goes in one byte per cycle through the same path, held
// while a compression runs, with one or two compressions in all.
// Reset loads the initial hash and clears the counters; no clearing pass.
// A digest holds in its output register until taken; bytes keep flowing,
// and the next end of message holds in the finish step until it is free.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_unit_assert.svh"

module sha256_byte_stream_hasher_unit (
	input logic           clk,
	input logic           arst_n,
	shabs_msg_if.sink     msg,
	shabs_digest_if.source digest
);
	import shabs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD80, ST_PADZ, ST_PADLEN, ST_COMP, ST_FINISH
	} state_t;

	state_t state_q, ret_q;
	count_t count_q;
	dword_t bits_q;
	logic   out_valid_q;
	dword_t dig0_q, dig1_q, dig2_q, dig3_q;

	ctrl_t ctrl;
	stat_t stat;
	word_t chain [8];
	logic  in_acc, wrap, fin_go;

	shabs_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.stat  (stat),
		.chain (chain)
	);

	assign msg.ready = (state_q == ST_IDLE);
	assign in_acc    = msg.valid && msg.ready;
	assign fin_go    = (state_q == ST_FINISH) && (!out_valid_q || digest.ready);

	always_comb begin
		ctrl.push      = 1'b0;
		ctrl.push_byte = '0;
		case (state_q)
			ST_IDLE: begin
				ctrl.push      = in_acc && msg.byte_present;
				ctrl.push_byte = msg.data_byte;
			end
			ST_PAD80: begin
				ctrl.push      = 1'b1;
				ctrl.push_byte = PAD_BYTE;
			end
			ST_PADZ:   ctrl.push = (count_q != LEN_OFFSET);
			ST_PADLEN: begin
				ctrl.push      = 1'b1;
				ctrl.push_byte = bits_q[63:56];
			end
			default: ctrl.push = 1'b0;
		endcase
		wrap        = ctrl.push && (count_q == COUNT_LAST);
		ctrl.start  = wrap;
		ctrl.reinit = fin_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			count_q     <= '0;
			bits_q      <= '0;
			out_valid_q <= 1'b0;
			dig0_q      <= '0;
			dig1_q      <= '0;
			dig2_q      <= '0;
			dig3_q      <= '0;
		end else begin
			if (ctrl.push) count_q <= count_q + 6'd1;
			if (fin_go) out_valid_q <= 1'b1;
			else if (out_valid_q && digest.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (msg.byte_present) bits_q <= bits_q + 64'd8;
						if (wrap) begin
							state_q <= ST_COMP;
							ret_q   <= msg.end_of_message ? ST_PAD80 : ST_IDLE;
						end else if (msg.end_of_message) begin
							state_q <= ST_PAD80;
						end
					end
				end
				ST_PAD80: begin
					state_q <= wrap ? ST_COMP : ST_PADZ;
					ret_q   <= ST_PADZ;
				end
				ST_PADZ: begin
					if (!ctrl.push) state_q <= ST_PADLEN;
					else if (wrap) begin
						state_q <= ST_COMP;
						ret_q   <= ST_PADZ;
					end
				end
				ST_PADLEN: begin
					bits_q <= {bits_q[55:0], 8'h00};
					if (wrap) begin
						state_q <= ST_COMP;
						ret_q   <= ST_FINISH;
					end
				end
				ST_COMP: begin
					if (stat.done) state_q <= ret_q;
				end
				ST_FINISH: begin
					if (fin_go) begin
						dig0_q      <= {chain[0], chain[1]};
						dig1_q      <= {chain[2], chain[3]};
						dig2_q      <= {chain[4], chain[5]};
						dig3_q      <= {chain[6], chain[7]};
						count_q     <= '0;
						bits_q      <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign digest.valid        = out_valid_q;
	assign digest.digest_word0 = dig0_q;
	assign digest.digest_word1 = dig1_q;
	assign digest.digest_word2 = dig2_q;
	assign digest.digest_word3 = dig3_q;

	`SHABS_ASSERT_NOW(a_start_core_idle, ctrl.start, !stat.busy)
	`SHABS_ASSERT_NOW(a_len_after_pad, state_q == ST_PADLEN, count_q >= LEN_OFFSET)
	`SHABS_ASSERT_NOW(a_comp_core_busy, state_q == ST_COMP, stat.busy)
	`SHABS_ASSERT_NEXT(a_finish_clears, fin_go, count_q == 6'd0 && bits_q == 64'd0 && out_valid_q)

endmodule

>>> src/shabs_core.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: compression core
// 512-bit block window filled one byte at a time, one shared round unit that
// runs 64 rounds over the window as a rolling schedule, then a fold into the
// chaining words.
// ----------------------------------------------------------------------------
module shabs_core (
	input  logic            clk,
	input  logic            arst_n,
	input  shabs_pkg::ctrl_t ctrl,
	output shabs_pkg::stat_t stat,
	output shabs_pkg::word_t chain [8]
);
	import shabs_pkg::*;

	typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FOLD} cstate_t;

	cstate_t      state_q;
	logic [5:0]   round_q;
	word_t        chain_q [8];
	word_t        var_q [8];
	logic [511:0] win_q;

	word_t w_t, w_new, t1, t2, ch, mj;

	always_comb begin
		w_t   = win_q[511:480];
		w_new = small_sigma1(win_q[63:32]) + win_q[223:192]
			+ small_sigma0(win_q[479:448]) + w_t;
		ch    = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
		mj    = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
		t1    = var_q[7] + big_sigma1(var_q[4]) + ch + ROUND_K[round_q] + w_t;
		t2    = big_sigma0(var_q[0]) + mj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			round_q <= '0;
			chain_q <= INIT_HASH;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (ctrl.reinit) chain_q <= INIT_HASH;
					if (ctrl.start) begin
						round_q <= '0;
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == COUNT_LAST) state_q <= C_FOLD;
				end
				C_FOLD: begin
					for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + var_q[i];
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// window: shift in bytes while filling, roll the schedule while rounding
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && ctrl.start) var_q <= chain_q;
		if (state_q == C_ROUND) begin
			win_q    <= {win_q[479:0], w_new};
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end else if (ctrl.push) begin
			win_q <= {win_q[503:0], ctrl.push_byte};
		end
	end

	assign stat.busy = (state_q != C_IDLE);
	assign stat.done = (state_q == C_FOLD);
	assign chain     = chain_q;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: testbench
// Drives message beats in random bursts, stalls the digest channel on a
// shifting pattern, and checks every digest against an in-bench SHA-256
// model fed from the accepted message beats.
// ----------------------------------------------------------------------------
module tb;
	import shabs_pkg::*;

	typedef logic [3:0][63:0] digest_t;

	localparam word_t K256 [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t H_START [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	class digest_board;
		word_t       hash_state [8];
		byte_t       block_bytes [64];
		int unsigned block_fill;
		logic [63:0] length_bits;
		digest_t     digests_due [$];
		int unsigned digests_seen;
		int unsigned errors;

		function new();
			restart();
			digests_seen = 0;
			errors = 0;
		endfunction

		function void restart();
			hash_state = H_START;
			block_fill = 0;
			length_bits = 64'd0;
		endfunction

		function word_t ror(word_t x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void run_rounds();
			word_t w [64];
			word_t v [8];
			word_t t1;
			word_t t2;
			int    i;
			for (i = 0; i < 16; i++)
				w[i] = {block_bytes[4*i], block_bytes[4*i+1],
					block_bytes[4*i+2], block_bytes[4*i+3]};
			for (i = 16; i < 64; i++)
				w[i] = w[i-16] + w[i-7]
					+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
					+ (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
			v = hash_state;
			for (i = 0; i < 64; i++) begin
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K256[i] + w[i];
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (i = 0; i < 8; i++)
				hash_state[i] = hash_state[i] + v[i];
		endfunction

		function void take_byte(byte_t b);
			block_bytes[block_fill] = b;
			block_fill = (block_fill + 1) % 64;
			if (block_fill == 0)
				run_rounds();
		endfunction

		function void note_beat(byte_t data, logic present, logic last);
			logic [63:0] len_field;
			digest_t     d;
			int          i;
			if (present) begin
				take_byte(data);
				length_bits = length_bits + 64'd8;
			end
			if (!last)
				return;
			len_field = length_bits;
			take_byte(8'h80);
			while (block_fill != 56)
				take_byte(8'h00);
			for (i = 0; i < 8; i++)
				take_byte(len_field[63 - 8*i -: 8]);
			for (i = 0; i < 4; i++)
				d[i] = {hash_state[2*i], hash_state[2*i+1]};
			digests_due = {digests_due, d};
			restart();
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check_digest(digest_t got);
			digest_t want;
			int      i;
			digests_seen++;
			if (digests_due.size() == 0) begin
				report($sformatf("digest %0d arrived with none due", digests_seen));
				return;
			end
			want = digests_due.pop_front();
			for (i = 0; i < 4; i++)
				if (got[i] !== want[i])
					report($sformatf("digest %0d digest_word%0d got %h want %h",
						digests_seen, i, got[i], want[i]));
		endtask

		function int pending();
			return digests_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	shabs_msg_if    msg_ch ();
	shabs_digest_if dig_ch ();

	sha256_byte_stream_hasher_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch)
	);

	digest_board board;
	int unsigned beats_sent;
	int unsigned burst_left;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic hold_off(int unsigned n);
		msg_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_beat(byte_t data, logic present, logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0)
				hold_off(gap);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 24);
		end
		burst_left--;
		msg_ch.valid <= 1'b1;
		msg_ch.data_byte <= data;
		msg_ch.byte_present <= present;
		msg_ch.end_of_message <= last;
		do
			@(posedge clk);
		while (msg_ch.ready !== 1'b1);
		board.note_beat(data, present, last);
		if (present || last)
			beats_sent++;
	endtask

	task automatic send_message(byte_t msg_bytes[$], bit split_end, bit noisy);
		int n;
		int i;
		n = msg_bytes.size();
		for (i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 7) == 0)
				send_beat(byte_t'($urandom), 1'b0, 1'b0);
			send_beat(msg_bytes[i], 1'b1, (i == n - 1) && !split_end);
		end
		if (split_end || n == 0)
			send_beat(byte_t'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		byte_t       body [$];
		int unsigned len;
		int          i;
		board = new();
		beats_sent = 0;
		burst_left = 0;
		arst_n <= 1'b0;
		msg_ch.valid <= 1'b0;
		msg_ch.data_byte <= 8'h00;
		msg_ch.byte_present <= 1'b0;
		msg_ch.end_of_message <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, then an ignored beat and a dropped byte
		send_beat(8'hff, 1'b0, 1'b1);
		send_beat(8'h5a, 1'b0, 1'b0);
		send_beat(8'hff, 1'b0, 1'b0);
		body = '{8'h61, 8'h62, 8'h63};
		send_message(body, 1'b0, 1'b0);
		body = '{8'h00};
		send_message(body, 1'b1, 1'b0);
		body = '{8'hff};
		send_message(body, 1'b0, 1'b0);
		// back-to-back ends: hash state must restart after each digest
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'haa, 1'b0, 1'b1);
		body = '{8'h00, 8'hff, 8'h55, 8'haa};
		send_message(body, 1'b1, 1'b1);

		while (beats_sent < 1550) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: len = $urandom_range(0, 12);
				4, 5: begin
					case ($urandom_range(0, 9))
						0: len = 55;
						1: len = 56;
						2: len = 57;
						3: len = 63;
						4: len = 64;
						5: len = 65;
						6: len = 119;
						7: len = 120;
						8: len = 127;
						default: len = 128;
					endcase
				end
				6, 7, 8: len = $urandom_range(13, 100);
				default: len = $urandom_range(101, 200);
			endcase
			body.delete();
			for (i = 0; i < len; i++)
				body = {body, byte_t'($urandom)};
			send_message(body, $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0);
		end

		hold_off(0);
		while (board.pending() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// digest channel: stall pattern switches between open, random and sparse
	initial begin
		digest_t     got;
		int unsigned stall_mode;
		int unsigned mode_left;
		int unsigned tick;
		stall_mode = 0;
		mode_left = 0;
		tick = 0;
		dig_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (dig_ch.valid === 1'b1 && dig_ch.ready === 1'b1) begin
				got[0] = dig_ch.digest_word0;
				got[1] = dig_ch.digest_word1;
				got[2] = dig_ch.digest_word2;
				got[3] = dig_ch.digest_word3;
				board.check_digest(got);
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(64, 400);
			end
			mode_left--;
			tick++;
			case (stall_mode)
				0: dig_ch.ready <= 1'b1;
				1: dig_ch.ready <= ($urandom_range(0, 1) == 1);
				default: dig_ch.ready <= (tick % 23) == 0;
			endcase
		end
	end

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end
endmodule
